// ===== rtl/skpl_pkg.sv =====
// Package for the soft-knee peak limiter: field widths, reset values,
// configuration register indexes and the request payload types.
// No dependencies; imported by soft_knee_peak_limiter.
`timescale 1ns / 1ps

package skpl_pkg;

  localparam int SAMPLE_W = 24;
  localparam int LEVEL_W  = 23;
  localparam int GAIN_W   = 23;
  localparam int COEF_W   = 17;
  localparam int FRAC_W   = 22;
  localparam int CFG_W    = 23;
  localparam int CFG_IDX_W = 2;

  localparam int DIV_STEPS = GAIN_W;

  localparam logic [GAIN_W-1:0]  UNITY_GAIN = GAIN_W'(1 << FRAC_W);
  localparam logic [COEF_W-1:0]  COEF_ONE   = COEF_W'(1 << (COEF_W - 1));

  localparam logic [LEVEL_W-1:0] THRESHOLD_RST = LEVEL_W'(3355443);
  localparam logic [LEVEL_W-1:0] KNEE_RST      = LEVEL_W'(209715);
  localparam logic [COEF_W-1:0]  ATTACK_RST    = COEF_W'(6554);
  localparam logic [COEF_W-1:0]  RELEASE_RST   = COEF_W'(655);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_KNEE      = 2'd1,
    REG_ATTACK    = 2'd2,
    REG_RELEASE   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       block_end;
  } skpl_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [GAIN_W-1:0]          gain_now;
    logic                       block_end_out;
  } skpl_out_t;

endpackage

// ===== rtl/soft_knee_peak_limiter.sv =====
// Top level of the soft-knee peak limiter: request channels, configuration
// registers, bit-serial divider, gain smoothing and output scaling.
// Depends on skpl_pkg.
`timescale 1ns / 1ps

// A sample whose magnitude does not exceed the threshold skips the divider and
// goes straight to gain smoothing and scaling. A louder sample first runs two
// 23-step restoring divisions that share one bit-serial divider, one quotient
// bit per cycle; the second is skipped when the threshold and the knee quotient
// are both zero. The finished request waits in the output register, so a new
// sample is accepted while the previous result is stalled.
// Configuration may only be written while no sample is in flight.
module soft_knee_peak_limiter
  import skpl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  skpl_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output skpl_out_t            out_data
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_EXCESS = 11'b00000000010,
    S_PREP1  = 11'b00000000100,
    S_DIV1   = 11'b00000001000,
    S_PREP2  = 11'b00000010000,
    S_DIV2   = 11'b00000100000,
    S_SCALE  = 11'b00001000000,
    S_MULT   = 11'b00010000000,
    S_UPDATE = 11'b00100000000,
    S_APPLY  = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

  state_t state;

  logic [LEVEL_W-1:0] threshold;
  logic [LEVEL_W-1:0] knee_width;
  logic [COEF_W-1:0]  attack_coef;
  logic [COEF_W-1:0]  release_coef;
  logic [GAIN_W-1:0]  gain;

  logic [SAMPLE_W-1:0] mag;
  logic                neg;
  logic                bend;
  logic [SAMPLE_W:0]   rem;
  logic [SAMPLE_W-1:0] den;
  logic [GAIN_W-1:0]   quo;
  logic [4:0]          cnt;
  logic [GAIN_W-1:0]   tgt;
  logic [GAIN_W-1:0]   diff;
  logic [COEF_W-1:0]   coef_sel;
  logic                fall;
  logic [GAIN_W-1:0]   step;
  logic [SAMPLE_W-1:0] prod_hi;

  logic [SAMPLE_W-1:0]   raw;
  logic [SAMPLE_W:0]     exc;
  logic                  over;
  logic [SAMPLE_W+1:0]   trial;
  logic                  ge;
  logic [SAMPLE_W:0]     rem_sub;
  logic [SAMPLE_W:0]     rem_next;
  logic [GAIN_W-1:0]     quo_next;
  logic [SAMPLE_W-1:0]   den_sum;
  logic [GAIN_W+COEF_W-1:0] step_prod;
  logic [SAMPLE_W+GAIN_W-1:0] out_prod;
  logic [COEF_W-1:0]     att_clamp;
  logic [COEF_W-1:0]     rel_clamp;
  logic                  out_load;
  logic [SAMPLE_W-1:0]   res_signed;

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  assign raw = in_data.sample_in;
  assign exc = {1'b0, mag} - {2'b0, threshold};
  assign over = !exc[SAMPLE_W] && (exc[SAMPLE_W-1:0] != '0);

  assign trial = {1'b0, rem} - {2'b0, den};
  assign ge = !trial[SAMPLE_W+1];
  assign rem_sub = ge ? trial[SAMPLE_W:0] : rem;
  assign rem_next = {rem_sub[SAMPLE_W-1:0], 1'b0};
  assign quo_next = {quo[GAIN_W-2:0], ge};

  assign den_sum = {1'b0, threshold} + {1'b0, quo};

  assign att_clamp = attack_coef[COEF_W-1] ? COEF_ONE : attack_coef;
  assign rel_clamp = release_coef[COEF_W-1] ? COEF_ONE : release_coef;

  assign step_prod = diff * coef_sel;
  assign out_prod = mag * gain;
  assign res_signed = neg ? (SAMPLE_W'(0) - prod_hi) : prod_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RST;
      knee_width   <= KNEE_RST;
      attack_coef  <= ATTACK_RST;
      release_coef <= RELEASE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_THRESHOLD: threshold    <= cfg_data[LEVEL_W-1:0];
        REG_KNEE:      knee_width   <= cfg_data[LEVEL_W-1:0];
        REG_ATTACK:    attack_coef  <= cfg_data[COEF_W-1:0];
        REG_RELEASE:   release_coef <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gain      <= UNITY_GAIN;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXCESS;
          end
        end
        S_EXCESS: begin
          if (over) begin
            state <= S_PREP1;
          end else begin
            state <= S_SCALE;
          end
        end
        S_PREP1: begin
          cnt   <= '0;
          state <= S_DIV1;
        end
        S_DIV1: begin
          cnt <= cnt + 5'd1;
          if (cnt == DIV_LAST) begin
            state <= S_PREP2;
          end
        end
        S_PREP2: begin
          cnt <= '0;
          if (den_sum == '0) begin
            state <= S_SCALE;
          end else begin
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          cnt <= cnt + 5'd1;
          if (cnt == DIV_LAST) begin
            state <= S_SCALE;
          end
        end
        S_SCALE:  state <= S_MULT;
        S_MULT:   state <= S_UPDATE;
        S_UPDATE: begin
          gain  <= fall ? (gain - step) : (gain + step);
          state <= S_APPLY;
        end
        S_APPLY:  state <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        neg  <= raw[SAMPLE_W-1];
        mag  <= raw[SAMPLE_W-1] ? (SAMPLE_W'(0) - raw) : raw;
        bend <= in_data.block_end;
      end
      S_EXCESS: begin
        rem <= {1'b0, exc[SAMPLE_W-1:0]};
        tgt <= UNITY_GAIN;
      end
      S_PREP1: begin
        den <= rem[SAMPLE_W-1:0] + {1'b0, knee_width};
      end
      S_DIV1, S_DIV2: begin
        rem <= rem_next;
        quo <= quo_next;
        if (state == S_DIV2 && cnt == DIV_LAST) begin
          tgt <= quo_next;
        end
      end
      S_PREP2: begin
        den <= den_sum;
        rem <= {2'b0, threshold};
        tgt <= '0;
      end
      S_SCALE: begin
        fall     <= (tgt < gain);
        diff     <= (tgt < gain) ? (gain - tgt) : (tgt - gain);
        coef_sel <= (tgt < gain) ? att_clamp : rel_clamp;
      end
      S_MULT: begin
        step <= step_prod[GAIN_W+COEF_W-2:COEF_W-1];
      end
      S_APPLY: begin
        prod_hi <= out_prod[FRAC_W+SAMPLE_W-1:FRAC_W];
      end
      S_DONE: begin
        if (out_load) begin
          out_data.sample_out    <= res_signed;
          out_data.gain_now      <= gain;
          out_data.block_end_out <= bend;
        end
      end
      default: ;
    endcase
  end

  // The smoothed gain only moves toward targets of at most unity.
  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    gain <= UNITY_GAIN)
    else $error("smoothed gain above unity");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_EXCESS)
    else $error("accepted request did not start processing");

  a_done_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && state == S_IDLE)
    else $error("finished request not presented at the output");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV1 || state == S_DIV2) |-> cnt <= DIV_LAST)
    else $error("divider step count out of range");

endmodule

// ===== test/soft_knee_peak_limiter_tb.sv =====
// Self-checking testbench for soft_knee_peak_limiter: directed corner cases and
// randomized audio samples under several register settings and idling patterns,
// checked against a cycle-free predictor. Depends on skpl_pkg and the RTL top.
`timescale 1ns / 1ps

module soft_knee_peak_limiter_tb;
  import skpl_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 64;
  localparam int PHASE_ITEMS    = 250;
  localparam int PHASE_COUNT    = 8;
  localparam int FULL_SCALE_MAG = 8388608;
  localparam int MAX_POSITIVE   = 8388607;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  skpl_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  skpl_out_t            out_data;

  logic [LEVEL_W-1:0] thr_reg;
  logic [LEVEL_W-1:0] knee_reg;
  logic [COEF_W-1:0]  attack_reg;
  logic [COEF_W-1:0]  release_reg;
  logic [GAIN_W-1:0]  model_gain;

  skpl_out_t expected_q[$];
  int        error_count = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_settings = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        quiet_cycles = 0;

  soft_knee_peak_limiter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    error_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Limiter predictor: target gain from the soft knee, smoothed gain update,
  // then the sample scaled by the new gain with truncation toward zero.
  function automatic skpl_out_t predict_limited(input skpl_in_t req);
    logic        neg;
    logic [63:0] raw, mag, excess, knee_q, den, target, gain, att, rel, prod;
    logic [SAMPLE_W-1:0] scaled;
    skpl_out_t   res;
    neg = req.sample_in[SAMPLE_W-1];
    raw = 64'({1'b0, req.sample_in});
    mag = neg ? (64'h1000000 - raw) : raw;
    if (mag <= 64'(thr_reg)) begin
      target = 64'(UNITY_GAIN);
    end else begin
      excess = mag - 64'(thr_reg);
      knee_q = (excess << FRAC_W) / (excess + 64'(knee_reg));
      den = 64'(thr_reg) + knee_q;
      target = (den == 64'd0) ? 64'd0 : ((64'(thr_reg) << FRAC_W) / den);
    end
    att = (attack_reg > COEF_ONE) ? 64'(COEF_ONE) : 64'(attack_reg);
    rel = (release_reg > COEF_ONE) ? 64'(COEF_ONE) : 64'(release_reg);
    gain = 64'(model_gain);
    if (target < gain) begin
      gain = gain - (((gain - target) * att) >> (COEF_W - 1));
    end else begin
      gain = gain + (((target - gain) * rel) >> (COEF_W - 1));
    end
    model_gain = gain[GAIN_W-1:0];
    prod = (mag * 64'(model_gain)) >> FRAC_W;
    scaled = prod[SAMPLE_W-1:0];
    if (neg) begin
      scaled = -scaled;
    end
    res.sample_out = scaled;
    res.gain_now = model_gain;
    res.block_end_out = req.block_end;
    return res;
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic blk_end);
    skpl_in_t req;
    req.sample_in = sample;
    req.block_end = blk_end;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data <= 25'($urandom());
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q = {expected_q, predict_limited(req)};
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_THRESHOLD: thr_reg = value[LEVEL_W-1:0];
      REG_KNEE:      knee_reg = value[LEVEL_W-1:0];
      REG_ATTACK:    attack_reg = value[COEF_W-1:0];
      REG_RELEASE:   release_reg = value[COEF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_limiter(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] knee,
                                 input logic [CFG_W-1:0] att, input logic [CFG_W-1:0] rel);
    drain();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_KNEE, knee);
    write_reg(REG_ATTACK, att);
    write_reg(REG_RELEASE, rel);
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [SAMPLE_W-1:0] signed_sample(input int unsigned mag, input bit neg);
    if (neg) begin
      return -SAMPLE_W'(mag);
    end
    return (mag > MAX_POSITIVE) ? SAMPLE_W'(MAX_POSITIVE) : SAMPLE_W'(mag);
  endfunction

  // Mix of full-range noise, quiet passages, samples hugging the threshold,
  // loud peaks and the extreme codes.
  function automatic logic [SAMPLE_W-1:0] random_sample();
    int unsigned thr, mag;
    bit          neg;
    thr = 32'(thr_reg);
    neg = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2: return SAMPLE_W'($urandom());
      3, 4:    mag = $urandom_range(0, thr);
      5, 6: begin
        mag = ((thr > 32) ? thr - 32 : 0) + $urandom_range(0, 64);
        if (mag > FULL_SCALE_MAG) mag = FULL_SCALE_MAG;
      end
      7: begin
        case ($urandom_range(0, 3))
          0: mag = FULL_SCALE_MAG;
          1: mag = MAX_POSITIVE;
          2: mag = 1;
          default: mag = 0;
        endcase
      end
      default: mag = $urandom_range(thr, FULL_SCALE_MAG);
    endcase
    return signed_sample(mag, neg);
  endfunction

  function automatic logic [CFG_W-1:0] random_coef();
    if ($urandom_range(0, 1) == 0) begin
      return CFG_W'($urandom_range(0, 65536));
    end
    return CFG_W'($urandom());
  endfunction

  always @(posedge clk) begin : result_check
    skpl_out_t want;
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_error($sformatf("result with nothing expected: %h", out_data));
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (out_data.sample_out !== want.sample_out) begin
          report_error($sformatf("result %0d sample_out %h, expected %h",
                                 n_checked, out_data.sample_out, want.sample_out));
        end
        if (out_data.gain_now !== want.gain_now) begin
          report_error($sformatf("result %0d gain_now %h, expected %h",
                                 n_checked, out_data.gain_now, want.gain_now));
        end
        if (out_data.block_end_out !== want.block_end_out) begin
          report_error($sformatf("result %0d block_end_out %b, expected %b",
                                 n_checked, out_data.block_end_out, want.block_end_out));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no request moved for %0d cycles", $realtime, quiet_cycles);
      $display("soft_knee_peak_limiter_tb: errors");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    send_sample(SAMPLE_W'(0), 1'b0);
    send_sample(SAMPLE_W'(1), 1'b1);
    send_sample(SAMPLE_W'(-1), 1'b0);
    send_sample(SAMPLE_W'(3355443), 1'b0);
    send_sample(SAMPLE_W'(3355444), 1'b1);
    send_sample(SAMPLE_W'(MAX_POSITIVE), 1'b0);
    send_sample(SAMPLE_W'(-FULL_SCALE_MAG), 1'b1);
    send_sample(SAMPLE_W'(-3355444), 1'b0);
    send_sample(SAMPLE_W'(1000), 1'b1);
  endtask

  // Coefficients above unity, including upper data bits beyond the register width.
  task automatic test_coef_clamp();
    program_limiter(23'd3355443, 23'd209715, 23'h7FFFFF, 23'd65537);
    send_sample(SAMPLE_W'(MAX_POSITIVE), 1'b0);
    send_sample(SAMPLE_W'(0), 1'b1);
    send_sample(SAMPLE_W'(-FULL_SCALE_MAG), 1'b0);
  endtask

  task automatic test_zero_knee();
    program_limiter(23'd3355443, 23'd0, 23'd6554, 23'd655);
    send_sample(SAMPLE_W'(3355444), 1'b0);
    send_sample(SAMPLE_W'(-FULL_SCALE_MAG), 1'b1);
    send_sample(SAMPLE_W'(3355443), 1'b0);
  endtask

  // Zero threshold with a knee so wide that the knee quotient truncates to zero.
  task automatic test_zero_threshold();
    program_limiter(23'd0, 23'h7FFFFF, 23'd65536, 23'd65536);
    send_sample(SAMPLE_W'(1), 1'b0);
    send_sample(SAMPLE_W'(-1), 1'b1);
    send_sample(SAMPLE_W'(2), 1'b0);
    send_sample(SAMPLE_W'(0), 1'b1);
  endtask

  task automatic test_high_threshold();
    program_limiter(23'h7FFFFF, 23'd1, 23'd32768, 23'd32768);
    send_sample(SAMPLE_W'(MAX_POSITIVE), 1'b0);
    send_sample(SAMPLE_W'(-FULL_SCALE_MAG), 1'b1);
  endtask

  // Frozen attack keeps unity gain, so a full-scale negative sample passes unchanged.
  task automatic test_full_scale_unity();
    program_limiter(23'd3355443, 23'd209715, 23'd0, 23'd65536);
    send_sample(SAMPLE_W'(0), 1'b0);
    send_sample(SAMPLE_W'(-FULL_SCALE_MAG), 1'b1);
  endtask

  task automatic test_random_phases();
    int send_pct[4] = '{0, 80, 0, 32};
    int recv_pct[4] = '{0, 0, 80, 32};
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: program_limiter(23'd3355443, 23'd209715, 23'd6554, 23'd655);
        1: program_limiter(23'd0, 23'd0, 23'd65536, 23'd65536);
        2: program_limiter(23'h7FFFFF, 23'h7FFFFF, 23'd0, 23'd0);
        3: program_limiter(23'd4194304, 23'd1, 23'h7FFFFF, 23'd65537);
        default: begin
          program_limiter(($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(1048576, 4194304))
                                                     : CFG_W'($urandom()),
                          CFG_W'($urandom()), random_coef(), random_coef());
        end
      endcase
      send_idle_pct = send_pct[p % 4];
      recv_stall_pct = recv_pct[p % 4];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) begin
          drain();
        end
        send_sample(random_sample(), 1'($urandom_range(0, 1)));
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    thr_reg = THRESHOLD_RST;
    knee_reg = KNEE_RST;
    attack_reg = ATTACK_RST;
    release_reg = RELEASE_RST;
    model_gain = UNITY_GAIN;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_coef_clamp();
    test_zero_knee();
    test_zero_threshold();
    test_high_threshold();
    test_full_scale_unity();
    test_random_phases();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      report_error($sformatf("%0d results never arrived", expected_q.size()));
    end

    $display("Covered %0d samples under %0d register settings; %0d results compared.",
             n_sent, n_settings, n_checked);
    $display("Idling: none, sender gaps, output stalls and both; %0d mismatches.",
             error_count);
    if (error_count == 0) begin
      $display("soft_knee_peak_limiter_tb: clean");
    end else begin
      $display("soft_knee_peak_limiter_tb: errors");
    end
    $finish;
  end

endmodule
